// ----- rtl/core/fleu_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash EEPROM log emulation package
// Sizes, operation and action codes, and the structs that pass between the
// control logic, the byte cache and the log slot flags.
// ----------------------------------------------------------------------------
package fleu_pkg;

    // Emulated EEPROM size: two data pages of PAGE_BYTES each.
    localparam int PAGE_BYTES = 4096;
    localparam int DATA_BYTES = 2 * PAGE_BYTES;
    localparam int BANK_AW    = $clog2(PAGE_BYTES);
    localparam int DATA_AW    = BANK_AW + 1;

    // Write log geometry.
    localparam int LOG_SLOTS = 1023;
    localparam int LOG_IW    = $clog2(LOG_SLOTS);
    localparam int LOG_CW    = $clog2(LOG_SLOTS + 1);

    // Fixed field widths.
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;
    localparam int SLOT_W = 10;

    // Highest byte address at which a whole word still fits.
    localparam logic [WORD_W-1:0] DATA_LAST   = WORD_W'(DATA_BYTES - 2);
    localparam logic [WORD_W-1:0] ERASED_WORD = 16'hffff;

    typedef enum logic [2:0] {
        OP_BEGIN       = 3'd0,
        OP_LOAD_WORD   = 3'd1,
        OP_REPLAY      = 3'd2,
        OP_READ_WORD   = 3'd3,
        OP_WRITE_WORD  = 3'd4,
        OP_WRITE_BYTE  = 3'd5,
        OP_FLUSH       = 3'd6,
        OP_ERASE       = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE          = 2'd0,
        ACT_APPEND        = 2'd1,
        ACT_COMPACT       = 2'd2,
        ACT_COMPACT_RESET = 2'd3
    } t_action;

    // One result item.
    typedef struct packed {
        t_action           action;
        logic [SLOT_W-1:0] log_slot;
        logic [WORD_W-1:0] log_address;
        logic [WORD_W-1:0] log_value;
        logic [WORD_W-1:0] read_value;
        logic              last;
    } t_result;

    // Byte cache access: one word read and one word write per cycle.
    typedef struct packed {
        logic               rd_en;
        logic [DATA_AW-1:0] rd_addr;
        logic               wr_en;
        logic [DATA_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_word;
    } t_cache_req;

    // Log slot flag access and erase control.
    typedef struct packed {
        logic              rd_en;
        logic [LOG_IW-1:0] rd_idx;
        logic              wr_en;
        logic [LOG_IW-1:0] wr_idx;
        logic              wr_flag;
        logic              clr_start;
        logic              clr_keep0;
    } t_log_req;

endpackage

// ----- rtl/core/flash_eeprom_log_emulation_unit.sv -----
// ----------------------------------------------------------------------------
// Flash EEPROM log emulation unit
// Keeps an emulated EEPROM as a byte cache plus the occupancy of an
// append-only flash write log, and issues the flash commands (log append,
// page compaction) that each operation needs.
//
//   Channel  | Signals                              | Flow
//   ---------+--------------------------------------+----------------------
//   input    | i_valid/o_ready, i_op..i_magic_ok    | one item per accept
//   output   | o_valid/i_ready, o_action..o_last    | one or two per item
//   config   | i_cfg_we, i_cfg_wdata                | write_through, no wait
//
// In the accept cycle an item reads both bytes of the word from the two cache
// banks and the log slot flag; the execute step then compares and writes back.
// An item with two results passes through a further step (S_SECOND).
// After reset, and after every erase of the log (begin, or a compaction that
// resets the log), the slot flags of all LOG_SLOTS (1023) slots are swept, with
// o_ready low. A stalled output holds the item in the execute step.
// ----------------------------------------------------------------------------
module flash_eeprom_log_emulation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [15:0] i_value,
    input  logic        i_magic_ok,
    // Result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_action,
    output logic [9:0]  o_log_slot,
    output logic [15:0] o_log_address,
    output logic [15:0] o_log_value,
    output logic [15:0] o_read_value,
    output logic        o_last,
    // Configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_SECOND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Held item.
    fleu_pkg::t_op                 r_op;
    logic [fleu_pkg::WORD_W-1:0]   r_address;
    logic [fleu_pkg::WORD_W-1:0]   r_value;
    logic                          r_magic;

    // Control state.
    logic [fleu_pkg::LOG_CW-1:0]   r_log_count;
    logic [fleu_pkg::LOG_CW-1:0]   n_log_count;
    logic [fleu_pkg::LOG_CW-1:0]   r_replay_pos;
    logic [fleu_pkg::LOG_CW-1:0]   n_replay_pos;
    logic                          r_replay_stop;
    logic                          n_replay_stop;
    logic                          r_ctrl_valid;
    logic                          n_ctrl_valid;
    logic                          r_dirty;
    logic                          n_dirty;
    logic                          r_write_through;

    // Output stage.
    logic                          r_out_valid;
    fleu_pkg::t_result             r_out;
    fleu_pkg::t_result             r_second;

    // Datapath.
    logic                          accept;
    logic                          out_free;
    logic                          exec_go;
    logic                          ld;
    fleu_pkg::t_result             ld_res;
    fleu_pkg::t_cache_req          cache_req;
    fleu_pkg::t_log_req            log_req;
    logic [fleu_pkg::BYTE_W-1:0]   cache_lo;
    logic [fleu_pkg::BYTE_W-1:0]   cache_hi;
    logic                          log_flag;
    logic                          log_busy;
    logic [fleu_pkg::WORD_W-1:0]   in_word_addr;

    logic [fleu_pkg::WORD_W-1:0]   word_addr;
    logic [fleu_pkg::WORD_W-1:0]   old_word;
    logic [fleu_pkg::WORD_W-1:0]   new_word;
    logic [fleu_pkg::WORD_W-1:0]   rd_word;
    logic [fleu_pkg::LOG_CW-1:0]   append_slot;
    logic                          word_ok;
    logic                          raw_ok;
    logic                          log_full;
    logic                          compact_reset;
    logic                          cache_wr;
    logic [fleu_pkg::WORD_W-1:0]   cache_wr_addr;
    logic [fleu_pkg::WORD_W-1:0]   cache_wr_word;
    logic                          log_wr;
    logic                          log_wr_flag;
    logic [fleu_pkg::LOG_CW-1:0]   log_wr_idx;
    logic                          clr_start;
    logic                          clr_keep0;
    fleu_pkg::t_result             res0;
    fleu_pkg::t_result             res1;
    logic [1:0]                    res_cnt;

    // Handshakes.
    assign o_ready  = (r_state == S_IDLE) && !log_busy;
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign exec_go  = (r_state == S_EXEC) && out_free;

    // Read requests go out in the accept cycle; the cache address comes straight from the item.
    assign in_word_addr = (fleu_pkg::t_op'(i_op) == fleu_pkg::OP_WRITE_BYTE) ?
                          {i_address[15:1], 1'b0} : i_address;

    always_comb begin
        cache_req.rd_en   = accept;
        cache_req.rd_addr = in_word_addr[fleu_pkg::DATA_AW-1:0];
        cache_req.wr_en   = exec_go && cache_wr;
        cache_req.wr_addr = cache_wr_addr[fleu_pkg::DATA_AW-1:0];
        cache_req.wr_word = cache_wr_word;

        log_req.rd_en     = accept;
        log_req.rd_idx    = r_log_count[fleu_pkg::LOG_IW-1:0];
        log_req.wr_en     = exec_go && log_wr;
        log_req.wr_idx    = log_wr_idx[fleu_pkg::LOG_IW-1:0];
        log_req.wr_flag   = log_wr_flag;
        log_req.clr_start = exec_go && clr_start;
        log_req.clr_keep0 = clr_keep0;
    end

    fleu_byte_cache u_cache (
        .i_clk (i_clk),
        .i_req (cache_req),
        .o_lo  (cache_lo),
        .o_hi  (cache_hi)
    );

    fleu_log_flags u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (log_req),
        .o_flag  (log_flag),
        .o_busy  (log_busy)
    );

    // Operand preparation for the execute step.
    assign word_addr = (r_op == fleu_pkg::OP_WRITE_BYTE) ?
                       {r_address[15:1], 1'b0} : r_address;
    assign old_word  = {cache_hi, cache_lo};
    assign new_word  = (r_op != fleu_pkg::OP_WRITE_BYTE) ? r_value :
                       r_address[0] ? {r_value[7:0], cache_lo} :
                                      {cache_hi, r_value[7:0]};
    assign word_ok   = word_addr <= fleu_pkg::DATA_LAST;
    assign raw_ok    = r_address <= fleu_pkg::DATA_LAST;
    assign log_full  = r_log_count >= fleu_pkg::LOG_CW'(fleu_pkg::LOG_SLOTS);
    assign compact_reset = !r_ctrl_valid || (r_log_count != '0);
    assign append_slot   = log_full ? '0 : r_log_count;

    // Execute step: state update, write-back and results.
    always_comb begin
        n_log_count   = r_log_count;
        n_replay_pos  = r_replay_pos;
        n_replay_stop = r_replay_stop;
        n_ctrl_valid  = r_ctrl_valid;
        n_dirty       = r_dirty;
        cache_wr      = 1'b0;
        cache_wr_addr = r_address;
        cache_wr_word = r_value;
        log_wr        = 1'b0;
        log_wr_idx    = r_replay_pos;
        log_wr_flag   = 1'b0;
        clr_start     = 1'b0;
        clr_keep0     = 1'b0;
        rd_word       = '0;
        res0          = '0;
        res1          = '0;
        res_cnt       = 2'd0;

        unique case (r_op) inside
            fleu_pkg::OP_BEGIN: begin
                // The log image is erased; a bad control page in write-through
                // mode is rebuilt at once.
                clr_start     = 1'b1;
                n_log_count   = '0;
                n_replay_pos  = '0;
                n_replay_stop = 1'b0;
                n_ctrl_valid  = r_magic;
                if (!r_magic && r_write_through) begin
                    res0.action  = fleu_pkg::ACT_COMPACT_RESET;
                    res_cnt      = 2'd1;
                    n_ctrl_valid = 1'b1;
                end
            end
            fleu_pkg::OP_LOAD_WORD: begin
                cache_wr = raw_ok;
            end
            fleu_pkg::OP_REPLAY: begin
                // Record the entry; with a valid control page, apply it until an out-of-range address.
                if (r_replay_pos < fleu_pkg::LOG_CW'(fleu_pkg::LOG_SLOTS)) begin
                    log_wr       = 1'b1;
                    log_wr_flag  = !((r_address == fleu_pkg::ERASED_WORD) &&
                                     (r_value == fleu_pkg::ERASED_WORD));
                    n_replay_pos = r_replay_pos + fleu_pkg::LOG_CW'(1);
                    if (r_ctrl_valid && !r_replay_stop) begin
                        if (!raw_ok) begin
                            n_replay_stop = 1'b1;
                        end else begin
                            cache_wr    = 1'b1;
                            n_log_count = r_log_count + fleu_pkg::LOG_CW'(1);
                        end
                    end
                end
            end
            fleu_pkg::OP_READ_WORD: begin
                rd_word = raw_ok ? old_word : '0;
            end
            fleu_pkg::OP_WRITE_WORD, fleu_pkg::OP_WRITE_BYTE: begin
                if (word_ok && (new_word != old_word)) begin
                    cache_wr      = 1'b1;
                    cache_wr_addr = word_addr;
                    cache_wr_word = new_word;
                    // A full log is compacted before anything else.
                    if (log_full) begin
                        res0.action  = fleu_pkg::ACT_COMPACT_RESET;
                        res_cnt      = 2'd1;
                        n_log_count  = '0;
                        n_ctrl_valid = 1'b1;
                        clr_start    = 1'b1;
                    end
                    if (r_write_through) begin
                        if (!log_full && log_flag) begin
                            // Slot already programmed: compact instead.
                            res0.action = compact_reset ? fleu_pkg::ACT_COMPACT_RESET :
                                                          fleu_pkg::ACT_COMPACT;
                            res_cnt     = 2'd1;
                            if (compact_reset) begin
                                n_log_count  = '0;
                                n_ctrl_valid = 1'b1;
                                clr_start    = 1'b1;
                            end
                        end else begin
                            if (log_full) begin
                                res1.action      = fleu_pkg::ACT_APPEND;
                                res1.log_slot    = fleu_pkg::SLOT_W'(append_slot);
                                res1.log_address = word_addr;
                                res1.log_value   = new_word;
                                res_cnt          = 2'd2;
                                clr_keep0        = 1'b1;
                            end else begin
                                res0.action      = fleu_pkg::ACT_APPEND;
                                res0.log_slot    = fleu_pkg::SLOT_W'(append_slot);
                                res0.log_address = word_addr;
                                res0.log_value   = new_word;
                                res_cnt          = 2'd1;
                                log_wr           = 1'b1;
                                log_wr_idx       = r_log_count;
                                log_wr_flag      = 1'b1;
                            end
                            n_log_count = append_slot + fleu_pkg::LOG_CW'(1);
                        end
                    end else begin
                        n_dirty = 1'b1;
                    end
                end
            end
            fleu_pkg::OP_FLUSH, fleu_pkg::OP_ERASE: begin
                // Flush compacts a dirty cache, erase compacts in write-through.
                if (((r_op == fleu_pkg::OP_FLUSH) && r_dirty) ||
                    ((r_op == fleu_pkg::OP_ERASE) && r_write_through)) begin
                    res0.action = compact_reset ? fleu_pkg::ACT_COMPACT_RESET :
                                                  fleu_pkg::ACT_COMPACT;
                    res_cnt     = 2'd1;
                    if (compact_reset) begin
                        n_log_count  = '0;
                        n_ctrl_valid = 1'b1;
                        clr_start    = 1'b1;
                    end
                end
                if (r_op == fleu_pkg::OP_FLUSH) begin
                    n_dirty = 1'b0;
                end
            end
        endcase

        // Every item gives at least one result, and the final one is marked.
        if (res_cnt == 2'd0) begin
            res0.read_value = rd_word;
            res_cnt         = 2'd1;
        end
        if (res_cnt == 2'd1) begin
            res0.last = 1'b1;
        end else begin
            res1.last = 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = (res_cnt == 2'd2) ? S_SECOND : S_IDLE;
                end
            end
            S_SECOND: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign ld     = exec_go || ((r_state == S_SECOND) && out_free);
    assign ld_res = (r_state == S_SECOND) ? r_second : res0;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_log_count     <= '0;
            r_replay_pos    <= '0;
            r_replay_stop   <= 1'b0;
            r_ctrl_valid    <= 1'b0;
            r_dirty         <= 1'b0;
            r_write_through <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_write_through <= i_cfg_wdata;
            end
            if (exec_go) begin
                r_log_count   <= n_log_count;
                r_replay_pos  <= n_replay_pos;
                r_replay_stop <= n_replay_stop;
                r_ctrl_valid  <= n_ctrl_valid;
                r_dirty       <= n_dirty;
            end
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= fleu_pkg::t_op'(i_op);
            r_address <= i_address;
            r_value   <= i_value;
            r_magic   <= i_magic_ok;
        end
        if (exec_go) begin
            r_second <= res1;
        end
        if (ld) begin
            r_out <= ld_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_action      = r_out.action;
    assign o_log_slot    = r_out.log_slot;
    assign o_log_address = r_out.log_address;
    assign o_log_value   = r_out.log_value;
    assign o_read_value  = r_out.read_value;
    assign o_last        = r_out.last;

    // A log reset sent out must start the slot flag sweep.
    a_reset_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && (res0.action == fleu_pkg::ACT_COMPACT_RESET)) |=> log_busy)
        else $error("log reset issued without a flag sweep");

    // The held second result is always the final one of its item.
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SECOND) |-> r_second.last)
        else $error("second result not marked last");

    // The log count never passes the number of slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_log_count <= fleu_pkg::LOG_CW'(fleu_pkg::LOG_SLOTS))
        else $error("log count out of range");

    // An append names a real slot.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == fleu_pkg::ACT_APPEND)) |->
        (32'(o_log_slot) < fleu_pkg::LOG_SLOTS))
        else $error("append slot out of range");

endmodule

// ----- rtl/core/fleu_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module fleu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fleu_byte_cache.sv -----
// ----------------------------------------------------------------------------
// Byte cache
// The emulated EEPROM bytes live in two banks, even and odd addresses, so a
// word at any byte address, aligned or not, is read or written with one access to each bank.
// ----------------------------------------------------------------------------
module fleu_byte_cache (
    input  logic                        i_clk,
    input  fleu_pkg::t_cache_req        i_req,
    output logic [fleu_pkg::BYTE_W-1:0] o_lo,
    output logic [fleu_pkg::BYTE_W-1:0] o_hi
);

    logic [fleu_pkg::BANK_AW-1:0] rd_idx;
    logic [fleu_pkg::BANK_AW-1:0] wr_idx;
    logic [fleu_pkg::BANK_AW-1:0] even_raddr;
    logic [fleu_pkg::BANK_AW-1:0] even_waddr;
    logic [fleu_pkg::BYTE_W-1:0]  even_wdata;
    logic [fleu_pkg::BYTE_W-1:0]  odd_wdata;
    logic [fleu_pkg::BYTE_W-1:0]  even_q;
    logic [fleu_pkg::BYTE_W-1:0]  odd_q;
    logic                         r_rd_odd;

    // An odd word address takes its low byte from the odd bank and its high
    // byte from the next row of the even bank.
    assign rd_idx     = i_req.rd_addr[fleu_pkg::DATA_AW-1:1];
    assign even_raddr = i_req.rd_addr[0] ? rd_idx + fleu_pkg::BANK_AW'(1) : rd_idx;

    assign wr_idx     = i_req.wr_addr[fleu_pkg::DATA_AW-1:1];
    assign even_waddr = i_req.wr_addr[0] ? wr_idx + fleu_pkg::BANK_AW'(1) : wr_idx;
    assign even_wdata = i_req.wr_addr[0] ? i_req.wr_word[15:8] : i_req.wr_word[7:0];
    assign odd_wdata  = i_req.wr_addr[0] ? i_req.wr_word[7:0]  : i_req.wr_word[15:8];

    fleu_ram #(
        .WIDTH (fleu_pkg::BYTE_W),
        .DEPTH (fleu_pkg::PAGE_BYTES)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (even_waddr),
        .i_wdata (even_wdata),
        .i_re    (i_req.rd_en),
        .i_raddr (even_raddr),
        .o_rdata (even_q)
    );

    fleu_ram #(
        .WIDTH (fleu_pkg::BYTE_W),
        .DEPTH (fleu_pkg::PAGE_BYTES)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (wr_idx),
        .i_wdata (odd_wdata),
        .i_re    (i_req.rd_en),
        .i_raddr (rd_idx),
        .o_rdata (odd_q)
    );

    // Remember the byte order of the outstanding read.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_odd <= i_req.rd_addr[0];
        end
    end

    assign o_lo = r_rd_odd ? odd_q  : even_q;
    assign o_hi = r_rd_odd ? even_q : odd_q;

endmodule

// ----- rtl/core/fleu_log_flags.sv -----
// ----------------------------------------------------------------------------
// Log slot flags
// One bit per write log slot: set when the slot holds a programmed entry.
// Only that bit is ever looked at, so the entry itself is not kept. An erase
// sweeps the whole flag memory, one slot per cycle; an append into slot zero
// that comes together with the erase is folded into the sweep.
// ----------------------------------------------------------------------------
module fleu_log_flags (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fleu_pkg::t_log_req i_req,
    output logic               o_flag,
    output logic               o_busy
);

    localparam logic [fleu_pkg::LOG_IW-1:0] LAST_IDX =
        fleu_pkg::LOG_IW'(fleu_pkg::LOG_SLOTS - 1);

    logic                        r_busy;
    logic [fleu_pkg::LOG_IW-1:0] r_idx;
    logic                        r_keep0;
    logic                        mem_we;
    logic [fleu_pkg::LOG_IW-1:0] mem_waddr;
    logic                        mem_wdata;

    // Erase sweep; also runs once after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_idx   <= '0;
            r_keep0 <= 1'b0;
        end else if (i_req.clr_start) begin
            r_busy  <= 1'b1;
            r_idx   <= '0;
            r_keep0 <= i_req.clr_keep0;
        end else if (r_busy) begin
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + fleu_pkg::LOG_IW'(1);
            end
        end
    end

    // The sweep owns the write port while it runs.
    assign mem_we    = r_busy || i_req.wr_en;
    assign mem_waddr = r_busy ? r_idx : i_req.wr_idx;
    assign mem_wdata = r_busy ? (r_keep0 && (r_idx == '0)) : i_req.wr_flag;

    fleu_ram #(
        .WIDTH (1),
        .DEPTH (fleu_pkg::LOG_SLOTS)
    ) u_flag_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_idx),
        .o_rdata (o_flag)
    );

    assign o_busy = r_busy;

endmodule

// ----- tb/flash_eeprom_log_emulation_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Flash EEPROM log emulation unit testbench
// Drives begin, load, replay, read, write, flush and erase items into the
// unit. It runs both caching modes, includes a full log and random start-up
// sessions, and checks every flash command item against an in-bench model
// of the byte cache and the write log.
// ----------------------------------------------------------------------------
module flash_eeprom_log_emulation_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fleu_pkg::*;

    localparam int unsigned WIN_BYTES     = 16;
    localparam int unsigned HI_WIN        = DATA_BYTES - WIN_BYTES;
    localparam int          RANDOM_ITEMS  = 200;
    localparam int          SETTLE_CYCLES = 8;

    // DUT ports, all inputs at known values from time zero.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [2:0]  i_op        = OP_BEGIN;
    logic [15:0] i_address   = 16'h0000;
    logic [15:0] i_value     = 16'h0000;
    logic        i_magic_ok  = 1'b0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [1:0]  o_action;
    logic [9:0]  o_log_slot;
    logic [15:0] o_log_address;
    logic [15:0] o_log_value;
    logic [15:0] o_read_value;
    logic        o_last;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_wdata = 1'b0;

    // Shadow copy of the emulated EEPROM and the log image.
    logic [7:0]  cache_img [DATA_BYTES];
    logic [31:0] log_img   [LOG_SLOTS];
    int unsigned log_used    = 0;
    int unsigned replay_pos  = 0;
    bit          replay_halt = 1'b0;
    bit          ctrl_valid  = 1'b0;
    bit          cache_dirty = 1'b0;
    bit          wt_mode     = 1'b0;

    // Flash commands of the item being modeled, and those still due.
    t_result step_cmds[$];
    t_result flash_cmds_due[$];

    int fail_count = 0;
    int idle_pct   = 30;
    int items_sent = 0;

    flash_eeprom_log_emulation_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_value      (i_value),
        .i_magic_ok   (i_magic_ok),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_action     (o_action),
        .o_log_slot   (o_log_slot),
        .o_log_address(o_log_address),
        .o_log_value  (o_log_value),
        .o_read_value (o_read_value),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the unit
    // ------------------------------------------------------------------

    function automatic void wipe_log();
        foreach (log_img[i]) log_img[i] = '1;
    endfunction

    function automatic void add_cmd(t_action act, logic [9:0] slot, logic [15:0] addr,
                                    logic [15:0] val, logic [15:0] rd);
        t_result r;
        r.action      = act;
        r.log_slot    = slot;
        r.log_address = addr;
        r.log_value   = val;
        r.read_value  = rd;
        r.last        = 1'b0;
        step_cmds.push_back(r);
    endfunction

    // A compaction also resets the log when the log holds entries or the
    // control page is not valid.
    function automatic void compact_pages();
        if (!ctrl_valid || log_used != 0) begin
            wipe_log();
            log_used   = 0;
            ctrl_valid = 1'b1;
            add_cmd(ACT_COMPACT_RESET, '0, '0, '0, '0);
        end else begin
            add_cmd(ACT_COMPACT, '0, '0, '0, '0);
        end
    endfunction

    function automatic void store_word(logic [15:0] addr, logic [15:0] val);
        if (addr > DATA_LAST) return;
        if (cache_img[addr] == val[7:0] && cache_img[addr + 1] == val[15:8]) return;
        if (log_used >= LOG_SLOTS) compact_pages();
        cache_img[addr]     = val[7:0];
        cache_img[addr + 1] = val[15:8];
        if (wt_mode) begin
            // Append only into an erased slot; otherwise compact.
            if (log_used >= LOG_SLOTS || log_img[log_used] != 32'hffff_ffff) begin
                compact_pages();
            end else begin
                log_img[log_used] = {val, addr};
                add_cmd(ACT_APPEND, 10'(log_used), addr, val, '0);
                log_used++;
            end
        end else begin
            cache_dirty = 1'b1;
        end
    endfunction

    function automatic void emulate_eeprom_op(t_op op, logic [15:0] addr,
                                              logic [15:0] val, logic magic);
        logic [15:0] rd;
        logic [15:0] al;
        logic [15:0] merged;
        int          n;
        rd = '0;
        case (op)
            OP_BEGIN: begin
                wipe_log();
                log_used    = 0;
                replay_pos  = 0;
                replay_halt = 1'b0;
                ctrl_valid  = magic;
                if (!magic && wt_mode) compact_pages();
            end
            OP_LOAD_WORD: begin
                if (addr <= DATA_LAST) begin
                    cache_img[addr]     = val[7:0];
                    cache_img[addr + 1] = val[15:8];
                end
            end
            OP_REPLAY: begin
                // Every entry up to the last slot is recorded; it is applied only while replay runs.
                if (replay_pos < LOG_SLOTS) begin
                    log_img[replay_pos] = {val, addr};
                    replay_pos++;
                    if (ctrl_valid && !replay_halt) begin
                        if (addr > DATA_LAST) begin
                            replay_halt = 1'b1;
                        end else begin
                            cache_img[addr]     = val[7:0];
                            cache_img[addr + 1] = val[15:8];
                            log_used++;
                        end
                    end
                end
            end
            OP_READ_WORD: begin
                if (addr <= DATA_LAST) rd = {cache_img[addr + 1], cache_img[addr]};
            end
            OP_WRITE_WORD: begin
                store_word(addr, val);
            end
            OP_WRITE_BYTE: begin
                al = addr & 16'hfffe;
                if (al <= DATA_LAST) begin
                    if (addr[0]) merged = {val[7:0], cache_img[al]};
                    else         merged = {cache_img[al + 1], val[7:0]};
                    store_word(al, merged);
                end
            end
            OP_FLUSH: begin
                if (cache_dirty) begin
                    compact_pages();
                    cache_dirty = 1'b0;
                end
            end
            default: begin
                if (wt_mode) compact_pages();
            end
        endcase
        if (step_cmds.size() == 0) add_cmd(ACT_NONE, '0, '0, '0, rd);
        n = step_cmds.size() - 1;
        step_cmds[n].last = 1'b1;
        foreach (step_cmds[i]) flash_cmds_due.push_back(step_cmds[i]);
        step_cmds.delete();
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // Each accepted result item is compared with the oldest expected one.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (flash_cmds_due.size() == 0) begin
                report_mismatch("result item with no expected item pending");
            end else begin
                want = flash_cmds_due.pop_front();
                check_field("action", 16'(o_action), 16'(want.action));
                check_field("log_slot", 16'(o_log_slot), 16'(want.log_slot));
                check_field("log_address", o_log_address, want.log_address);
                check_field("log_value", o_log_value, want.log_value);
                check_field("read_value", o_read_value, want.read_value);
                check_field("last", 16'(o_last), 16'(want.last));
            end
        end
    end

    // Result side: ready drops at random.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= idle_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one item and hold it until the unit accepts it. Valid stays
    // high afterwards until the next item or an idle phase lowers it.
    task automatic send_item(t_op op, logic [15:0] addr, logic [15:0] val, logic magic);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_address  <= addr;
        i_value    <= val;
        i_magic_ok <= magic;
        emulate_eeprom_op(op, addr, val, magic);
        items_sent++;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (flash_cmds_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_write_through(bit wt);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wt;
        wt_mode = wt;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Word or byte address inside the preloaded windows at both ends.
    function automatic logic [15:0] window_addr(bit byte_op);
        int unsigned off;
        off = $urandom_range(0, byte_op ? WIN_BYTES - 1 : WIN_BYTES - 2);
        return $urandom_range(1) ? 16'(off) : 16'(HI_WIN + off);
    endfunction

    function automatic logic [15:0] flipped_word(logic [15:0] addr);
        return ~{cache_img[addr + 1], cache_img[addr]};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Give the bytes at both ends of the cache known values.
    task automatic test_preload();
        set_write_through(1'b0);
        for (int a = 0; a < WIN_BYTES; a += 2) begin
            send_item(OP_LOAD_WORD, 16'(a), (a == 0) ? 16'h0000 : 16'($urandom), 1'b0);
            send_item(OP_LOAD_WORD, 16'(HI_WIN + a),
                      (a == WIN_BYTES - 2) ? 16'hffff : 16'($urandom), 1'b1);
        end
        // Loads past the last whole word are dropped.
        send_item(OP_LOAD_WORD, 16'(DATA_BYTES - 1), 16'hffff, 1'b0);
        send_item(OP_LOAD_WORD, 16'hffff, 16'h1234, 1'b1);
        wait_idle();
    endtask

    // Reads and writes at the edges of the address range, write-back mode.
    task automatic test_word_access();
        send_item(OP_BEGIN, 16'h0000, 16'h0000, 1'b1);
        send_item(OP_READ_WORD, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_READ_WORD, DATA_LAST, 16'hffff, 1'b1);
        send_item(OP_READ_WORD, 16'(DATA_BYTES - 1), 16'h0000, 1'b0);
        send_item(OP_READ_WORD, 16'hffff, 16'hffff, 1'b1);
        // Unchanged data, an odd word address, and a word past the end.
        send_item(OP_WRITE_WORD, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_WRITE_WORD, DATA_LAST, 16'hffff, 1'b0);
        send_item(OP_WRITE_WORD, 16'h0001, 16'ha5c3, 1'b0);
        send_item(OP_WRITE_WORD, 16'(DATA_BYTES - 1), 16'h5a5a, 1'b0);
        // Byte merges into both halves of a word, and a byte past the end.
        send_item(OP_WRITE_BYTE, 16'h0003, 16'hff7e, 1'b0);
        send_item(OP_WRITE_BYTE, DATA_LAST, 16'h0000, 1'b0);
        send_item(OP_WRITE_BYTE, 16'(DATA_BYTES - 1), 16'h00ff, 1'b0);
        send_item(OP_WRITE_BYTE, 16'hffff, 16'h0012, 1'b0);
        send_item(OP_READ_WORD, 16'h0002, 16'h0000, 1'b0);
        // A dirty cache is compacted once; erase does nothing in this mode.
        send_item(OP_FLUSH, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_FLUSH, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_ERASE, 16'h0000, 16'h0000, 1'b0);
        wait_idle();
    endtask

    // Appends to the log, and a begin without a valid control page.
    task automatic test_write_through();
        set_write_through(1'b1);
        send_item(OP_ERASE, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_WRITE_WORD, 16'h0004, flipped_word(16'h0004), 1'b0);
        send_item(OP_WRITE_BYTE, 16'h0005, 16'h00c9 ^ {8'h00, cache_img[5]}, 1'b0);
        send_item(OP_WRITE_BYTE, 16'h0005, {8'h00, cache_img[5]}, 1'b0);
        send_item(OP_BEGIN, 16'h0000, 16'h0000, 1'b0);
        wait_idle();
    endtask

    // Replay with an invalid control page, a replay that stops, and a stop
    // on an erased entry.
    task automatic test_replay();
        set_write_through(1'b0);
        send_item(OP_BEGIN, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_REPLAY, 16'h0006, 16'h3c3c, 1'b0);
        wait_idle();
        set_write_through(1'b1);
        // The first slot holds the recorded entry, so the write compacts.
        send_item(OP_WRITE_WORD, 16'h0008, flipped_word(16'h0008), 1'b0);
        send_item(OP_WRITE_WORD, 16'h000a, flipped_word(16'h000a), 1'b0);
        send_item(OP_BEGIN, 16'h0000, 16'h0000, 1'b1);
        send_item(OP_REPLAY, 16'h0002, 16'($urandom), 1'b0);
        send_item(OP_REPLAY, DATA_LAST, 16'($urandom), 1'b0);
        send_item(OP_REPLAY, 16'h3000, 16'($urandom), 1'b0);
        send_item(OP_REPLAY, 16'h0004, 16'($urandom), 1'b0);
        send_item(OP_WRITE_WORD, 16'h000c, flipped_word(16'h000c), 1'b0);
        send_item(OP_BEGIN, 16'h0000, 16'h0000, 1'b1);
        send_item(OP_REPLAY, 16'hffff, 16'hffff, 1'b0);
        send_item(OP_WRITE_WORD, 16'h000e, flipped_word(16'h000e), 1'b0);
        wait_idle();
    endtask

    // Fill the log by replay; the next write compacts and then appends.
    task automatic test_log_full();
        send_item(OP_BEGIN, 16'h0000, 16'h0000, 1'b1);
        repeat (LOG_SLOTS) begin
            send_item(OP_REPLAY, 16'($urandom_range(0, DATA_LAST)), 16'($urandom), 1'b0);
        end
        // Replay beyond the last slot is ignored.
        send_item(OP_REPLAY, 16'h0010, 16'h1111, 1'b0);
        send_item(OP_WRITE_WORD, 16'h0000, flipped_word(16'h0000), 1'b0);
        send_item(OP_WRITE_BYTE, 16'h0001, 16'h005a ^ {8'h00, cache_img[1]}, 1'b0);
        wait_idle();
    endtask

    // One random cache access, or now and then a stray start-up item.
    task automatic send_access();
        int unsigned pick;
        t_op         op;
        logic [15:0] addr;
        logic [15:0] val;
        bit          same;
        pick = $urandom_range(99);
        same = ($urandom_range(99) < 30);
        val  = 16'($urandom);
        if (pick < 25)      op = OP_READ_WORD;
        else if (pick < 55) op = OP_WRITE_WORD;
        else if (pick < 85) op = OP_WRITE_BYTE;
        else if (pick < 93) op = OP_FLUSH;
        else if (pick < 97) op = OP_ERASE;
        else                op = t_op'($urandom_range(2));
        if (op == OP_READ_WORD || op == OP_WRITE_WORD) begin
            if ($urandom_range(99) < 85) begin
                addr = window_addr(1'b0);
                if (same) val = {cache_img[addr + 1], cache_img[addr]};
            end else begin
                addr = 16'($urandom_range(DATA_BYTES - 1, 16'hffff));
            end
        end else if (op == OP_WRITE_BYTE) begin
            if ($urandom_range(99) < 85) begin
                addr = window_addr(1'b1);
                if (same) val[7:0] = cache_img[addr];
            end else begin
                addr = 16'($urandom_range(DATA_BYTES, 16'hffff));
            end
        end else begin
            addr = 16'($urandom);
        end
        send_item(op, addr, val, 1'($urandom_range(1)));
    endtask

    // Random start-up sessions, each followed by cache traffic. Every
    // fourth session runs without idle cycles.
    task automatic test_random();
        int first;
        int phase;
        int n;
        first = items_sent;
        phase = 0;
        while (items_sent - first < RANDOM_ITEMS) begin
            idle_pct = (phase % 4 == 3) ? 0 : 30;
            set_write_through(1'($urandom_range(1)));
            send_item(OP_BEGIN, 16'($urandom), 16'($urandom), ($urandom_range(99) < 85));
            n = $urandom_range(4);
            repeat (n) begin
                send_item(OP_LOAD_WORD, 16'($urandom_range(0, DATA_LAST)), 16'($urandom),
                          1'($urandom_range(1)));
            end
            n = $urandom_range(8);
            repeat (n) begin
                send_item(OP_REPLAY, 16'($urandom_range(0, DATA_LAST)), 16'($urandom),
                          1'($urandom_range(1)));
            end
            // Sometimes the log ends in an out-of-range entry and up to two more follow.
            if ($urandom_range(99) < 25) begin
                send_item(OP_REPLAY, 16'($urandom_range(DATA_BYTES - 1, 16'hffff)),
                          16'($urandom), 1'($urandom_range(1)));
                n = $urandom_range(2);
                repeat (n) send_item(OP_REPLAY, 16'($urandom), 16'($urandom), 1'b0);
            end
            n = $urandom_range(20, 40);
            repeat (n) send_access();
            wait_idle();
            phase++;
        end
        idle_pct = 30;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        foreach (cache_img[i]) cache_img[i] = 8'h00;
        wipe_log();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_preload();
        test_word_access();
        test_write_through();
        test_replay();
        test_log_full();
        test_random();
        wait_idle();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop in case the unit hangs.
    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
